/* src/pbo_pkg.sv */
// shared constants, types and sine table builder for the polyblep oscillator
package pbo_pkg;

    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
    localparam int QUARTER_SIZE    = SINE_SIZE / 4;
    localparam int SAMPLE_W        = 17;
    localparam int BLEP_W          = 17;
    localparam int QUO_W           = 15;
    localparam int CNT_W           = $clog2(QUO_W);
    localparam int INTEG_W         = 32;
    localparam int MUL_A_W         = 33;
    localparam int MUL_B_W         = ((PHASE_BITS > 24) ? PHASE_BITS : 24) + 1;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [2:0] wave_t;
    typedef logic [1:0] reg_idx_t;
    typedef logic signed [15:0] sine_rom_t [SINE_SIZE];

    localparam logic [PHASE_BITS:0] PHASE_ONE  = (PHASE_BITS+1)'(1) << PHASE_BITS;
    localparam phase_t              PHASE_HALF = phase_t'(1) << (PHASE_BITS - 1);
    localparam logic [63:0]         ONE_64     = 64'd1 << PHASE_BITS;
    localparam phase_t              PW_MIN     = phase_t'(ONE_64 / 100);
    localparam phase_t              PW_MAX     = phase_t'((ONE_64 * 99) / 100);
    localparam logic [23:0]         LEAK_COEF  = 24'd16775538;
    localparam logic [15:0]         ONE_Q15    = 16'd32768;

    localparam wave_t WAVE_SINE     = 3'd0;
    localparam wave_t WAVE_SAW      = 3'd1;
    localparam wave_t WAVE_RSAW     = 3'd2;
    localparam wave_t WAVE_SQUARE   = 3'd3;
    localparam wave_t WAVE_TRIANGLE = 3'd4;

    localparam reg_idx_t REG_PHASE_INC   = 2'd0;
    localparam reg_idx_t REG_PULSE_WIDTH = 2'd1;
    localparam reg_idx_t REG_WAVE_SHAPE  = 2'd2;

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam logic [63:0] TAYLOR_DIV [12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // taylor series on the first quadrant, q.61
    function automatic logic [63:0] sin_q61(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_q61(x, x);
        term = x;
        sum  = x;
        for (int n = 0; n < 12; n++) begin
            term = mul_q61(term, x2) / TAYLOR_DIV[n];
            if (n[0] == 1'b0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic signed [15:0] quarter_sine(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        x = (PI_Q61 >> (SINE_TABLE_BITS - 1)) * r;
        s = sin_q61(x) >> 21;
        v = (64'd32767 * s + (64'd1 << 39)) >> 40;
        return v[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic signed [15:0] v;
        logic [63:0]        r;
        int                 quad;
        for (int k = 0; k < SINE_SIZE; k++) begin
            quad = k / QUARTER_SIZE;
            r    = 64'(k % QUARTER_SIZE);
            v    = quad[0] ? quarter_sine(64'(QUARTER_SIZE) - r) : quarter_sine(r);
            rom[k] = quad[1] ? -v : v;
        end
        return rom;
    endfunction

endpackage

/* src/polyblep_oscillator.sv */
// band-limited oscillator: phase accumulator, sine rom, polyblep saw/square, leaky triangle
// per accepted beat: step residual setup, then sample formation; square and triangle set up
// two residuals, and triangle then runs the leak and drive multiplies and the integrator update
// each active step residual adds a restoring divider run and a squaring on the shared multiplier
// one item at a time; next beat is taken the cycle after the result is registered
// synchronous active-low reset clears phase, integrator and registers to their defaults
module polyblep_oscillator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbo_pkg::ADDR_W-1:0]          paddr,
    input  logic [pbo_pkg::DATA_W-1:0]          pwdata,
    output logic [pbo_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pbo_pkg::SAMPLE_W-1:0] m_sample_value,
    output logic                                m_phase_wrapped
);
    import pbo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BLEP_SETUP,
        ST_DIV,
        ST_SQ_MUL,
        ST_SQ_DONE,
        ST_LEAK_MUL,
        ST_DRIVE_MUL,
        ST_TRI,
        ST_FORM
    } state_t;

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam logic signed [PROD_W-1:0] LEAK_RND  = PROD_W'(1) << 23;
    localparam logic signed [PROD_W-1:0] DRIVE_RND = PROD_W'(1) << (PHASE_BITS - 12);
    localparam logic signed [33:0]       ACC_MAX   = 34'sd2147483647;
    localparam logic signed [33:0]       ACC_MIN   = -34'sd2147483648;
    localparam logic signed [24:0]       ONE_S     = 25'sd32768;
    localparam logic signed [24:0]       SAT_MAX   = 25'sd65535;
    localparam logic signed [24:0]       SAT_MIN   = -25'sd65536;

    // configuration
    phase_t inc_reg;
    phase_t pw_reg;
    wave_t  shape_reg;

    // sequencer and datapath
    state_t                     state_reg;
    phase_t                     phase_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    phase_t                     t_reg;
    logic                       pass_reg;
    phase_t                     rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       neg_reg;
    logic signed [BLEP_W-1:0]   blep0_reg;
    logic signed [BLEP_W-1:0]   blep1_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [32:0]         leak_reg;
    logic signed [15:0]         sine_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_wrap_reg;

    logic                       cfg_write;
    reg_idx_t                   cfg_idx;
    phase_t                     cfg_data;
    phase_t                     blep_arg;
    logic [PHASE_BITS:0]        one_minus_dt;
    logic                       arg_lo;
    logic                       arg_hi;
    logic [PHASE_BITS:0]        rem_dbl;
    logic                       rem_ge;
    logic [PHASE_BITS:0]        rem_sub;
    logic [15:0]                d_val;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]          sq_round;
    logic signed [BLEP_W-1:0]   blep_mag;
    logic signed [BLEP_W-1:0]   blep_val;
    logic signed [18:0]         sq_base;
    logic signed [18:0]         sq_val;
    logic signed [PROD_W-1:0]   leak_round;
    logic signed [PROD_W-1:0]   drive_round;
    logic signed [32:0]         drive_val;
    logic signed [33:0]         acc;
    logic signed [INTEG_W-1:0]  acc_sat;
    logic signed [32:0]         tri_round;
    logic signed [23:0]         tri_val;
    logic signed [24:0]         saw_s;
    logic signed [24:0]         s_raw;
    logic signed [SAMPLE_W-1:0] s_sat;
    logic [PHASE_BITS:0]        phase_sum;
    logic                       blep_shape;
    logic                       two_pass;
    state_t                     after_blep;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_data  = pwdata[PHASE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg   <= '0;
            pw_reg    <= PHASE_HALF;
            shape_reg <= WAVE_SAW;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_PHASE_INC: begin
                    inc_reg <= (cfg_data > PHASE_HALF) ? PHASE_HALF : cfg_data;
                end
                REG_PULSE_WIDTH: begin
                    pw_reg <= (cfg_data < PW_MIN) ? PW_MIN :
                              (cfg_data > PW_MAX) ? PW_MAX : cfg_data;
                end
                REG_WAVE_SHAPE: begin
                    shape_reg <= pwdata[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PHASE_INC:   prdata = DATA_W'(inc_reg);
            REG_PULSE_WIDTH: prdata = DATA_W'(pw_reg);
            REG_WAVE_SHAPE:  prdata = DATA_W'(shape_reg);
            default:         prdata = '0;
        endcase
    end

    // registered sine rom read
    always_ff @(posedge aclk) begin
        sine_reg <= SINE_ROM[t_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]];
    end

    // step residual setup and divider
    assign blep_shape = (shape_reg == WAVE_SAW) || (shape_reg == WAVE_RSAW) ||
                        (shape_reg == WAVE_SQUARE) || (shape_reg == WAVE_TRIANGLE);
    assign two_pass   = (shape_reg == WAVE_SQUARE) || (shape_reg == WAVE_TRIANGLE);
    assign after_blep = (two_pass && !pass_reg) ? ST_BLEP_SETUP :
                        (shape_reg == WAVE_TRIANGLE) ? ST_LEAK_MUL : ST_FORM;

    assign blep_arg     = pass_reg ? (t_reg - pw_reg) : t_reg;
    assign one_minus_dt = PHASE_ONE - {1'b0, inc_reg};
    assign arg_lo       = blep_arg < inc_reg;
    assign arg_hi       = {1'b0, blep_arg} > one_minus_dt;
    assign rem_dbl      = {rem_reg, 1'b0};
    assign rem_ge       = rem_dbl >= {1'b0, inc_reg};
    assign rem_sub      = rem_dbl - {1'b0, inc_reg};
    assign d_val        = ONE_Q15 - {1'b0, quo_reg};

    // shared multiplier
    always_comb begin
        case (state_reg)
            ST_SQ_MUL: begin
                mul_a = $signed(MUL_A_W'(d_val));
                mul_b = $signed(MUL_B_W'(d_val));
            end
            ST_LEAK_MUL: begin
                mul_a = MUL_A_W'(integ_reg);
                mul_b = $signed(MUL_B_W'(LEAK_COEF));
            end
            ST_DRIVE_MUL: begin
                mul_a = MUL_A_W'(sq_val);
                mul_b = $signed(MUL_B_W'(inc_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sq_round = prod_reg + PROD_W'(16384);
    assign blep_mag = $signed(sq_round[31:15]);
    assign blep_val = neg_reg ? -blep_mag : blep_mag;

    assign sq_base = (t_reg < pw_reg) ? 19'sd32768 : -19'sd32768;
    assign sq_val  = sq_base + 19'(blep0_reg) - 19'(blep1_reg);

    // leaky integrator
    assign leak_round  = prod_reg + LEAK_RND;
    assign drive_round = prod_reg + DRIVE_RND;
    assign drive_val   = $signed(drive_round[PHASE_BITS-11 +: 33]);
    assign acc         = 34'(leak_reg) + 34'(drive_val);
    assign acc_sat     = (acc > ACC_MAX) ? ACC_MAX[INTEG_W-1:0] :
                         (acc < ACC_MIN) ? ACC_MIN[INTEG_W-1:0] : acc[INTEG_W-1:0];
    assign tri_round   = 33'(integ_reg) + 33'sd256;
    assign tri_val     = $signed(tri_round[32:9]);

    // sample formation
    assign saw_s = $signed({9'd0, t_reg[PHASE_BITS-1 -: 16]});

    always_comb begin
        case (shape_reg)
            WAVE_SINE:     s_raw = 25'(sine_reg);
            WAVE_SAW:      s_raw = saw_s - ONE_S - 25'(blep0_reg);
            WAVE_RSAW:     s_raw = ONE_S - saw_s + 25'(blep0_reg);
            WAVE_SQUARE:   s_raw = 25'(sq_val);
            WAVE_TRIANGLE: s_raw = 25'(tri_val);
            default:       s_raw = '0;
        endcase
    end

    assign s_sat     = (s_raw > SAT_MAX) ? SAT_MAX[SAMPLE_W-1:0] :
                       (s_raw < SAT_MIN) ? SAT_MIN[SAMPLE_W-1:0] : s_raw[SAMPLE_W-1:0];
    assign phase_sum = {1'b0, t_reg} + {1'b0, inc_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            phase_reg   <= '0;
            integ_reg   <= '0;
            pass_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_FORM)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        t_reg    <= s_restart ? '0 : phase_reg;
                        pass_reg <= 1'b0;
                        if (s_restart) begin
                            integ_reg <= '0;
                        end
                        state_reg <= ST_BLEP_SETUP;
                    end
                end
                ST_BLEP_SETUP: begin
                    if (!blep_shape) begin
                        state_reg <= ST_FORM;
                    end else if (arg_lo || arg_hi) begin
                        rem_reg   <= arg_lo ? blep_arg : phase_t'(PHASE_ONE - {1'b0, blep_arg});
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        neg_reg   <= arg_lo;
                        state_reg <= ST_DIV;
                    end else begin
                        if (pass_reg) begin
                            blep1_reg <= '0;
                        end else begin
                            blep0_reg <= '0;
                        end
                        pass_reg  <= 1'b1;
                        state_reg <= after_blep;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_ge ? rem_sub[PHASE_BITS-1:0] : rem_dbl[PHASE_BITS-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQ_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_DONE;
                end
                ST_SQ_DONE: begin
                    if (pass_reg) begin
                        blep1_reg <= blep_val;
                    end else begin
                        blep0_reg <= blep_val;
                    end
                    pass_reg  <= 1'b1;
                    state_reg <= after_blep;
                end
                ST_LEAK_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DRIVE_MUL;
                end
                ST_DRIVE_MUL: begin
                    leak_reg  <= $signed(leak_round[24 +: 33]);
                    prod_reg  <= mul_p;
                    state_reg <= ST_TRI;
                end
                ST_TRI: begin
                    integ_reg <= acc_sat;
                    state_reg <= ST_FORM;
                end
                ST_FORM: begin
                    if (!m_valid_reg || m_ready) begin
                        m_sample_reg <= s_sat;
                        m_wrap_reg   <= phase_sum[PHASE_BITS];
                        m_valid_reg  <= 1'b1;
                        phase_reg    <= phase_sum[PHASE_BITS-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_sample_value  = m_sample_reg;
    assign m_phase_wrapped = m_wrap_reg;

endmodule

/* src/pbo_checker.sv */
// port-level checks for the polyblep oscillator, bound to the top level
module pbo_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                pready,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [pbo_pkg::SAMPLE_W-1:0] m_sample_value,
    input logic                                m_phase_wrapped
);
    import pbo_pkg::*;

    // busy in the cycle after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // no result can appear the cycle after a beat is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // a new result coincides with the sequencer going idle
    a_result_with_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result raised while still busy");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_value) && $stable(m_phase_wrapped))
        else $error("stalled result beat changed");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind polyblep_oscillator pbo_checker u_pbo_checker (.*);

/* tb/tb.sv */
// testbench for the polyblep oscillator: bit-exact sample predictor, scoreboard and handshake drivers
`timescale 1ns / 100ps

module tb;
    import pbo_pkg::*;

    localparam longint   PHASE_FULL = longint'(1) << PHASE_BITS;
    localparam longint   PHASE_MASK = PHASE_FULL - 1;
    localparam longint   INTEG_MAX  = (longint'(1) << 31) - 1;
    localparam longint   INTEG_MIN  = -(longint'(1) << 31);
    localparam reg_idx_t REG_SPARE  = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       wrapped;
    } osc_result_t;

    class osc_sample_board;
        longint      phase_acc;
        longint      tri_acc;
        longint      step_inc;
        longint      duty;
        wave_t       shape;
        int          sine_tab[SINE_SIZE];
        osc_result_t expected_samples[$];
        int          failures;

        function new();
            int quad;
            int r;
            int v;
            for (int k = 0; k < SINE_SIZE; k++) begin
                quad = k / QUARTER_SIZE;
                r    = k % QUARTER_SIZE;
                v    = quad[0] ? quarter_wave(QUARTER_SIZE - r) : quarter_wave(r);
                sine_tab[k] = quad[1] ? -v : v;
            end
            phase_acc = 0;
            tri_acc   = 0;
            step_inc  = 0;
            duty      = PHASE_FULL / 2;
            shape     = WAVE_SAW;
            failures  = 0;
        endfunction

        function bit [63:0] fmul(bit [63:0] a, bit [63:0] b);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[124:61];
        endfunction

        // first quadrant, taylor series in q.61
        function int quarter_wave(int r);
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] term;
            bit [63:0] acc;
            x    = (PI_Q61 >> (SINE_TABLE_BITS - 1)) * 64'(r);
            x2   = fmul(x, x);
            term = x;
            acc  = x;
            for (int n = 1; n <= 12; n++) begin
                term = fmul(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            acc = acc >> 21;
            return int'((64'd32767 * acc + (64'd1 << 39)) >> 40);
        endfunction

        function longint step_residual(longint t, longint dt);
            longint d;
            if (t < dt) begin
                d = 32768 - ((t << 15) / dt);
                return -((d * d + 16384) >>> 15);
            end
            if (t > PHASE_FULL - dt) begin
                d = 32768 - (((PHASE_FULL - t) << 15) / dt);
                return (d * d + 16384) >>> 15;
            end
            return 0;
        endfunction

        function longint pulse_level(longint t, longint dt);
            longint v;
            v = (t < duty) ? 32768 : -32768;
            v = v + step_residual(t, dt);
            v = v - step_residual((t + PHASE_FULL - duty) & PHASE_MASK, dt);
            return v;
        endfunction

        function void write_reg(reg_idx_t idx, longint value);
            longint v;
            v = value & PHASE_MASK;
            case (idx)
                REG_PHASE_INC: begin
                    step_inc = (v > PHASE_FULL / 2) ? PHASE_FULL / 2 : v;
                end
                REG_PULSE_WIDTH: begin
                    if (v < longint'(PW_MIN)) begin
                        duty = longint'(PW_MIN);
                    end else if (v > longint'(PW_MAX)) begin
                        duty = longint'(PW_MAX);
                    end else begin
                        duty = v;
                    end
                end
                REG_WAVE_SHAPE: begin
                    shape = wave_t'(value & 7);
                end
                default: begin
                end
            endcase
        endfunction

        function void note_tick(bit restart);
            longint      t;
            longint      dt;
            longint      s;
            longint      leak;
            longint      drive;
            longint      acc;
            osc_result_t r;
            dt = step_inc;
            if (restart) begin
                phase_acc = 0;
                tri_acc   = 0;
            end
            t = phase_acc;
            case (shape)
                WAVE_SINE: s = sine_tab[t >> (PHASE_BITS - SINE_TABLE_BITS)];
                WAVE_SAW: s = (t >> (PHASE_BITS - 16)) - 32768 - step_residual(t, dt);
                WAVE_RSAW: s = 32768 - (t >> (PHASE_BITS - 16)) + step_residual(t, dt);
                WAVE_SQUARE: s = pulse_level(t, dt);
                WAVE_TRIANGLE: begin
                    leak  = (tri_acc * longint'(LEAK_COEF) + (longint'(1) << 23)) >>> 24;
                    drive = (dt * pulse_level(t, dt) + (longint'(1) << (PHASE_BITS - 12)))
                            >>> (PHASE_BITS - 11);
                    acc = leak + drive;
                    if (acc > INTEG_MAX) acc = INTEG_MAX;
                    if (acc < INTEG_MIN) acc = INTEG_MIN;
                    tri_acc = acc;
                    s = (acc + 256) >>> 9;
                end
                default: s = 0;
            endcase
            if (s > 65535) s = 65535;
            if (s < -65536) s = -65536;
            phase_acc = t + dt;
            r.wrapped = (phase_acc >= PHASE_FULL);
            if (r.wrapped) phase_acc = phase_acc - PHASE_FULL;
            r.value = s[SAMPLE_W-1:0];
            expected_samples.push_back(r);
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] value, logic wrapped);
            osc_result_t r;
            if (expected_samples.size() == 0) begin
                $error("result beat with no sample expected: sample_value %0d", value);
                failures++;
                return;
            end
            r = expected_samples.pop_front();
            if (value !== r.value) begin
                $error("sample_value: expected %0d, got %0d", r.value, value);
                failures++;
            end
            if (wrapped !== r.wrapped) begin
                $error("phase_wrapped: expected %0b, got %0b", r.wrapped, wrapped);
                failures++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [ADDR_W-1:0]          paddr     = '0;
    logic [DATA_W-1:0]          pwdata    = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic                       s_restart = 1'b0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_value;
    logic                       m_phase_wrapped;

    osc_sample_board model;
    int              send_idle = 0;
    int              recv_idle = 0;

    polyblep_oscillator dut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            model.check_sample(m_sample_value, m_phase_wrapped);
        end
    end

    task automatic drain_results();
        s_valid <= 1'b0;
        while (model.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        model.write_reg(idx, longint'(value));
    endtask

    task automatic configure(input logic [23:0] inc, input logic [23:0] pw, input wave_t wave);
        drain_results();
        write_reg(REG_PHASE_INC, DATA_W'(inc));
        write_reg(REG_PULSE_WIDTH, DATA_W'(pw));
        write_reg(REG_WAVE_SHAPE, DATA_W'(wave));
        write_reg(REG_SPARE, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_tick(input bit restart);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        model.note_tick(restart);
    endtask

    initial begin
        logic [23:0] inc;
        logic [23:0] pw;
        wave_t       wave;
        model = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: saw with zero increment
        send_tick(1'b0);
        send_tick(1'b1);
        // increment saturates at one half, width clamps low
        configure(24'hFFFFFF, 24'h000000, WAVE_SAW);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        configure(24'hFFFFFF, 24'hFFFFFF, WAVE_RSAW);
        send_tick(1'b0);
        send_tick(1'b0);
        configure(24'd1000, 24'h000000, WAVE_SQUARE);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        configure(24'h800000, 24'hFFFFFF, WAVE_SQUARE);
        send_tick(1'b0);
        send_tick(1'b0);
        configure(24'h004000, 24'h800000, WAVE_SINE);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        configure(24'h001000, 24'h400000, WAVE_TRIANGLE);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        // unused shapes give silence but the phase still runs
        for (int w = int'(WAVE_TRIANGLE) + 1; w < 8; w++) begin
            configure(24'h200000, 24'h800000, wave_t'(w));
            send_tick(1'b0);
        end

        for (int seg = 0; seg < 15; seg++) begin
            case ($urandom_range(0, 7))
                0: inc = 24'd0;
                1: inc = 24'($urandom_range(24'h800000, 24'hFFFFFF));
                2: inc = 24'($urandom);
                default: inc = 24'($urandom_range(1, 24'h100000));
            endcase
            case ($urandom_range(0, 5))
                0: pw = 24'($urandom_range(0, int'(PW_MIN)));
                1: pw = 24'($urandom_range(int'(PW_MAX), 24'hFFFFFF));
                default: pw = 24'($urandom);
            endcase
            wave = (seg < 13) ? wave_t'(seg % 5) : wave_t'($urandom_range(5, 7));
            configure(inc, pw, wave);
            send_idle = (seg < 5) ? 11 : (seg < 10) ? 53 : 0;
            recv_idle = (seg < 5) ? 53 : (seg < 10) ? 11 : 0;
            repeat (83) send_tick($urandom_range(0, 99) < 3);
        end

        drain_results();
        repeat (60) @(posedge aclk);
        if (model.failures == 0 && model.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* polyblep_oscillator.f */
src/pbo_pkg.sv
src/polyblep_oscillator.sv
src/pbo_checker.sv
tb/tb.sv
